>>> design/qcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcs_pkg
// Shared types, widths and arithmetic helpers for the 1D quantum lattice
// Boltzmann collide-and-stream block.
// ----------------------------------------------------------------------------
package qcs_pkg;

    localparam int COMP_W     = 16;
    localparam int FRAC_W     = COMP_W - 2;
    localparam int PROD_W     = 2 * COMP_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int MAX_SITES  = 2048;
    localparam int MIN_SITES  = 3;
    localparam int INDEX_W    = 11;
    localparam int COUNT_W    = 12;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_SITE_COUNT = 1'b0;

    localparam longint COMP_MAX = (longint'(1) <<< (COMP_W - 1)) - 1;
    localparam longint COMP_MIN = -(longint'(1) <<< (COMP_W - 1));
    localparam longint HALF_LSB = longint'(1) <<< (FRAC_W - 1);

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef comp_t [3:0]              quad_t;   // 0: 1_re, 1: 1_im, 2: 2_re, 3: 2_im
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [INDEX_W-1:0]       index_t;
    typedef logic [COUNT_W-1:0]       count_t;

    typedef struct packed {
        comp_t up1_re;
        comp_t up1_im;
        comp_t up2_re;
        comp_t up2_im;
        comp_t down1_re;
        comp_t down1_im;
        comp_t down2_re;
        comp_t down2_im;
        comp_t coef_a_re;
        comp_t coef_a_im;
        comp_t coef_b_re;
        comp_t coef_b_im;
    } in_item_t;

    typedef struct packed {
        index_t site_index;
        comp_t  new_up1_re;
        comp_t  new_up1_im;
        comp_t  new_up2_re;
        comp_t  new_up2_im;
        comp_t  new_down1_re;
        comp_t  new_down1_im;
        comp_t  new_down2_re;
        comp_t  new_down2_im;
        logic   sweep_end;
    } out_item_t;

    // exact product, sign-extended to accumulator width
    function automatic acc_t mul_ext(comp_t x, comp_t y);
        logic signed [PROD_W-1:0] p;
        p = x * y;
        return acc_t'(p);
    endfunction

    // round half up at the fraction point, then clip to the component range
    function automatic comp_t round_sat(acc_t sum);
        acc_t t;
        acc_t q;
        t = sum + acc_t'(HALF_LSB);
        q = t >>> FRAC_W;
        if (q > acc_t'(COMP_MAX))
            return comp_t'(COMP_MAX);
        else if (q < acc_t'(COMP_MIN))
            return comp_t'(COMP_MIN);
        else
            return comp_t'(q[COMP_W-1:0]);
    endfunction

endpackage

>>> design/qcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcs_if
// Valid/ready stream channels: one for input sites, one for result sites.
// ----------------------------------------------------------------------------
interface qcs_in_if;
    logic               valid;
    logic               ready;
    qcs_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qcs_out_if;
    logic               valid;
    logic               ready;
    qcs_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/qcs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcs_cfg
// APB register port holding the site count of one periodic sweep.
// ----------------------------------------------------------------------------
module qcs_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qcs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qcs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qcs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output qcs_pkg::count_t                site_count
);
    import qcs_pkg::*;

    count_t site_count_reg;
    count_t site_count_next;
    logic   wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_SITE_COUNT);

    always_comb
    begin
        site_count_next = site_count_reg;
        if (wr_hit)
        begin
            site_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_count_reg <= count_t'(MAX_SITES);
        end
        else
        begin
            site_count_reg <= site_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SITE_COUNT)
        begin
            prdata = APB_DATA_W'(site_count_reg);
        end
    end

    assign site_count = site_count_reg;

endmodule

>>> design/qcs_collide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcs_collide
// Collision of one site: u' = a*u + b*d, d' = a*d - b*u, for both spinor
// pairs, with rounding and saturation to Q2.14.
// ----------------------------------------------------------------------------
module qcs_collide (
    input  qcs_pkg::in_item_t item,
    output qcs_pkg::quad_t    new_up,
    output qcs_pkg::quad_t    new_down
);
    import qcs_pkg::*;

    quad_t u;
    quad_t d;
    comp_t ar;
    comp_t ai;
    comp_t br;
    comp_t bi;

    always_comb
    begin
        u[0] = item.up1_re;
        u[1] = item.up1_im;
        u[2] = item.up2_re;
        u[3] = item.up2_im;
        d[0] = item.down1_re;
        d[1] = item.down1_im;
        d[2] = item.down2_re;
        d[3] = item.down2_im;
        ar   = item.coef_a_re;
        ai   = item.coef_a_im;
        br   = item.coef_b_re;
        bi   = item.coef_b_im;
    end

    // two independent pairs, four products summed exactly per component
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            new_up[2*k]     = round_sat(mul_ext(ar, u[2*k])   - mul_ext(ai, u[2*k+1])
                                      + mul_ext(br, d[2*k])   - mul_ext(bi, d[2*k+1]));
            new_up[2*k+1]   = round_sat(mul_ext(ar, u[2*k+1]) + mul_ext(ai, u[2*k])
                                      + mul_ext(br, d[2*k+1]) + mul_ext(bi, d[2*k]));
            new_down[2*k]   = round_sat(mul_ext(ar, d[2*k])   - mul_ext(ai, d[2*k+1])
                                      - mul_ext(br, u[2*k])   + mul_ext(bi, u[2*k+1]));
            new_down[2*k+1] = round_sat(mul_ext(ar, d[2*k+1]) + mul_ext(ai, d[2*k])
                                      - mul_ext(br, u[2*k+1]) - mul_ext(bi, u[2*k]));
        end
    end

endmodule

>>> design/qcs_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcs_stream
// Input register, sweep state and a three-entry result buffer. Streams the
// collided spinors: u' one site right, d' one site left, periodic wrap.
// ----------------------------------------------------------------------------
module qcs_stream (
    input  logic              clk,
    input  logic              rst_n,
    qcs_in_if.sink            sites,
    qcs_out_if.source         results,
    input  qcs_pkg::count_t   site_count,
    output qcs_pkg::in_item_t work_item,
    input  qcs_pkg::quad_t    new_up,
    input  qcs_pkg::quad_t    new_down
);
    import qcs_pkg::*;

    function automatic out_item_t make_result(index_t idx, quad_t up, quad_t dn, logic last);
        out_item_t r;
        r.site_index   = idx;
        r.new_up1_re   = up[0];
        r.new_up1_im   = up[1];
        r.new_up2_re   = up[2];
        r.new_up2_im   = up[3];
        r.new_down1_re = dn[0];
        r.new_down1_im = dn[1];
        r.new_down2_re = dn[2];
        r.new_down2_im = dn[3];
        r.sweep_end    = last;
        return r;
    endfunction

    in_item_t  item_reg;
    logic      item_valid_reg;
    logic      item_valid_next;
    index_t    counter_reg;
    index_t    counter_next;
    quad_t     up_hist0_reg;
    quad_t     up_hist1_reg;
    quad_t     first_down_reg;
    quad_t     second_down_reg;
    out_item_t slot_reg [3];
    logic [1:0] slot_cnt_reg;
    logic [1:0] slot_cnt_next;

    count_t    n_sites;
    logic      pop;
    logic      fire;
    logic      accept;
    logic      is_first;
    logic      is_second;
    logic      is_last;

    always_comb
    begin
        if (site_count < count_t'(MIN_SITES))
            n_sites = count_t'(MIN_SITES);
        else if (site_count > count_t'(MAX_SITES))
            n_sites = count_t'(MAX_SITES);
        else
            n_sites = site_count;
    end

    assign pop       = results.valid && results.ready;
    // advance the work register only once the buffer is empty or its last beat is leaving
    assign fire      = item_valid_reg &&
                       ((slot_cnt_reg == 2'd0) || ((slot_cnt_reg == 2'd1) && pop));
    assign sites.ready = !item_valid_reg || fire;
    assign accept    = sites.valid && sites.ready;
    assign work_item = item_reg;

    assign is_first  = (counter_reg == index_t'(0));
    assign is_second = (counter_reg == index_t'(1));
    assign is_last   = !is_first && !is_second &&
                       ({1'b0, counter_reg} >= (n_sites - count_t'(1)));

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = 1'b1;
        else if (fire)
            item_valid_next = 1'b0;

        counter_next  = counter_reg;
        slot_cnt_next = slot_cnt_reg;
        if (fire)
        begin
            if (is_last)
            begin
                counter_next  = index_t'(0);
                slot_cnt_next = 2'd3;
            end
            else
            begin
                counter_next  = counter_reg + index_t'(1);
                slot_cnt_next = (is_first || is_second) ? 2'd0 : 2'd1;
            end
        end
        else if (pop)
        begin
            slot_cnt_next = slot_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            counter_reg     <= '0;
            slot_cnt_reg    <= '0;
            up_hist0_reg    <= '0;
            up_hist1_reg    <= '0;
            first_down_reg  <= '0;
            second_down_reg <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            counter_reg    <= counter_next;
            slot_cnt_reg   <= slot_cnt_next;
            if (fire)
            begin
                up_hist1_reg <= up_hist0_reg;
                up_hist0_reg <= new_up;
                if (is_first)
                    first_down_reg <= new_down;
                if (is_second)
                    second_down_reg <= new_down;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= sites.data;
        end
        if (fire)
        begin
            slot_reg[0] <= make_result(counter_reg - index_t'(1), up_hist1_reg, new_down, 1'b0);
            slot_reg[1] <= make_result(counter_reg, up_hist0_reg, first_down_reg, 1'b0);
            slot_reg[2] <= make_result(index_t'(0), new_up, second_down_reg, 1'b1);
        end
        else if (pop)
        begin
            // drop the head beat, shift the rest down
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    assign results.valid = (slot_cnt_reg != 2'd0);
    assign results.data  = slot_reg[0];

endmodule

>>> design/qlb_collide_stream_1d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlb_collide_stream_1d_top
// One time step of the 1D quantum lattice Boltzmann scheme over a stream of
// lattice sites: collision followed by periodic streaming.
// ----------------------------------------------------------------------------
// Usage:
//   sites   - one beat per lattice site, in order 0..N-1 of the sweep: the four
//             complex spinor components and the coefficients a and b (Q2.14).
//   results - new sites 1..N-1 in order, then site 0 flagged by sweep_end.
//   APB     - register site_count (N, clamped to 3..2048) at address 0.
// Sites 0 and 1 give no beat, sites 2..N-2 one beat, the last site three.
// A site is captured in the work register on its beat; the combinational
// collision then loads its results into a three-entry buffer, so each
// result beat leaves from that buffer register. One site per cycle is
// taken while results drain at one per cycle; the last site of a sweep holds
// the input while its three beats leave the buffer. When the receiver stalls,
// the buffer holds its beats and at most one more site is taken into the work
// register. Reset empties both stages, restarts the sweep at site 0 and sets
// site_count to 2048.
// ----------------------------------------------------------------------------
module qlb_collide_stream_1d_top (
    input  logic                           clk,
    input  logic                           rst_n,
    qcs_in_if.sink                         sites,
    qcs_out_if.source                      results,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qcs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qcs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qcs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import qcs_pkg::*;

    count_t   site_count;
    in_item_t work_item;
    quad_t    new_up;
    quad_t    new_down;

    qcs_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .site_count (site_count)
    );

    qcs_collide u_collide (
        .item     (work_item),
        .new_up   (new_up),
        .new_down (new_down)
    );

    qcs_stream u_stream (
        .clk        (clk),
        .rst_n      (rst_n),
        .sites      (sites),
        .results    (results),
        .site_count (site_count),
        .work_item  (work_item),
        .new_up     (new_up),
        .new_down   (new_down)
    );

endmodule

>>> design/qcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcs_checker
// Port-level checks on the result channel of the collide-and-stream block.
// ----------------------------------------------------------------------------
module qcs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input qcs_pkg::out_item_t out_data
);
    import qcs_pkg::*;

    // the end-of-sweep beat always carries new site 0
    a_end_is_site0 : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sweep_end |-> out_data.site_index == index_t'(0))
        else $error("sweep_end beat not on site 0");

    // site 0 only ever appears as the end-of-sweep beat
    a_site0_is_end : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.sweep_end |-> out_data.site_index != index_t'(0))
        else $error("site 0 beat without sweep_end");

    // no result beat while held in reset
    a_reset_quiet : assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !out_valid)
        else $error("result beat during reset");

    // stalled beat holds
    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

endmodule

bind qlb_collide_stream_1d_top qcs_checker u_qcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);

>>> tb/sv/qlb_collide_stream_1d_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlb_collide_stream_1d_top_test
// Self-checking bench for the collide-and-stream block. Lattice sites are
// streamed through it and each result beat is compared against a local model
// of the collision, rounding, saturation and periodic streaming. A short
// table of hand-worked sites comes first. Random sweeps follow over a range
// of site_count settings, with random idling on both channels and a long
// result hold-off.
// ----------------------------------------------------------------------------
module qlb_collide_stream_1d_top_test;

    import qcs_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TOP_Q         = int'(COMP_MAX);
    localparam int BOT_Q         = int'(COMP_MIN);
    localparam int UNIT_Q        = 1 << FRAC_W;

    typedef struct {
        in_item_t  site;
        bit        typed;
        out_item_t want;
    } drill_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    qcs_in_if  site_ch ();
    qcs_out_if result_ch ();

    // lattice mirror
    count_t      cfg_site_count = count_t'(MAX_SITES);
    int unsigned sweep_pos = 0;
    quad_t       up_back1 = '0;
    quad_t       up_back2 = '0;
    quad_t       down_site0 = '0;
    quad_t       down_site1 = '0;

    out_item_t   step_out[$];
    out_item_t   awaited_sites[$];
    drill_row_t  drill[$];

    bit          gap_on = 1'b0;
    bit          stall_on = 1'b0;
    bit          hold_request = 1'b0;
    int          sites_sent = 0;
    int          results_seen = 0;
    int          sweeps_closed = 0;
    int          writes_done = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    qlb_collide_stream_1d_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sites   (site_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic quad_t q4(input int re1, input int im1, input int re2, input int im2);
        quad_t q;
        q[0] = comp_t'(re1);
        q[1] = comp_t'(im1);
        q[2] = comp_t'(re2);
        q[3] = comp_t'(im2);
        return q;
    endfunction

    function automatic quad_t flat_quad(input int v);
        return q4(v, v, v, v);
    endfunction

    function automatic in_item_t make_site(input quad_t u, input quad_t d, input int ar,
                                           input int ai, input int br, input int bi);
        in_item_t s;
        s.up1_re    = u[0];
        s.up1_im    = u[1];
        s.up2_re    = u[2];
        s.up2_im    = u[3];
        s.down1_re  = d[0];
        s.down1_im  = d[1];
        s.down2_re  = d[2];
        s.down2_im  = d[3];
        s.coef_a_re = comp_t'(ar);
        s.coef_a_im = comp_t'(ai);
        s.coef_b_re = comp_t'(br);
        s.coef_b_im = comp_t'(bi);
        return s;
    endfunction

    function automatic out_item_t make_result(input int unsigned pos, input quad_t u,
                                              input quad_t d, input bit closes);
        out_item_t r;
        r.site_index   = index_t'(pos);
        r.new_up1_re   = u[0];
        r.new_up1_im   = u[1];
        r.new_up2_re   = u[2];
        r.new_up2_im   = u[3];
        r.new_down1_re = d[0];
        r.new_down1_im = d[1];
        r.new_down2_re = d[2];
        r.new_down2_im = d[3];
        r.sweep_end    = closes;
        return r;
    endfunction

    // Q6.28 sum to Q2.14: add half an LSB, floor, clip
    function automatic comp_t fix_round(input longint acc);
        longint r;
        r = (acc + HALF_LSB) >>> FRAC_W;
        if (r > COMP_MAX)
            return comp_t'(COMP_MAX);
        if (r < COMP_MIN)
            return comp_t'(COMP_MIN);
        return comp_t'(r);
    endfunction

    function automatic void collide(input in_item_t s, output quad_t nu, output quad_t nd);
        quad_t  u;
        quad_t  d;
        longint ar, ai, br, bi, ur, ui, dr, di;
        int     k;
        u  = q4(s.up1_re, s.up1_im, s.up2_re, s.up2_im);
        d  = q4(s.down1_re, s.down1_im, s.down2_re, s.down2_im);
        ar = s.coef_a_re;
        ai = s.coef_a_im;
        br = s.coef_b_re;
        bi = s.coef_b_im;
        for (k = 0; k < 2; k++)
        begin
            ur = $signed(u[2*k]);
            ui = $signed(u[2*k+1]);
            dr = $signed(d[2*k]);
            di = $signed(d[2*k+1]);
            nu[2*k]   = fix_round(ar*ur - ai*ui + br*dr - bi*di);
            nu[2*k+1] = fix_round(ar*ui + ai*ur + br*di + bi*dr);
            nd[2*k]   = fix_round(ar*dr - ai*di - br*ur + bi*ui);
            nd[2*k+1] = fix_round(ar*di + ai*dr - br*ui - bi*ur);
        end
    endfunction

    function automatic int unsigned sweep_length();
        if (cfg_site_count < MIN_SITES)
            return MIN_SITES;
        if (cfg_site_count > MAX_SITES)
            return MAX_SITES;
        return cfg_site_count;
    endfunction

    // advance the lattice by one site, leaving the new sites it completes in step_out
    function automatic void step_lattice(input in_item_t s);
        quad_t       nu;
        quad_t       nd;
        int unsigned n;
        bit          wrap;
        n    = sweep_length();
        wrap = 1'b0;
        collide(s, nu, nd);
        if (sweep_pos == 0)
            down_site0 = nd;
        else if (sweep_pos == 1)
            down_site1 = nd;
        else
        begin
            step_out.push_back(make_result(sweep_pos - 1, up_back2, nd, 1'b0));
            // a site at or past the end closes the sweep and wraps site 0 round
            if (sweep_pos >= n - 1)
            begin
                step_out.push_back(make_result(sweep_pos, up_back1, down_site0, 1'b0));
                step_out.push_back(make_result(0, nu, down_site1, 1'b1));
                wrap = 1'b1;
            end
        end
        up_back2  = up_back1;
        up_back1  = nu;
        sweep_pos = wrap ? 0 : sweep_pos + 1;
    endfunction

    function automatic comp_t pick_comp();
        case ($urandom_range(0, 9))
            0:       return comp_t'(BOT_Q);
            1:       return comp_t'(TOP_Q);
            2:       return comp_t'(int'($urandom_range(0, 64)) - 32);
            3:       return comp_t'(UNIT_Q);
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic in_item_t rand_site();
        return make_site(q4(pick_comp(), pick_comp(), pick_comp(), pick_comp()),
                         q4(pick_comp(), pick_comp(), pick_comp(), pick_comp()),
                         pick_comp(), pick_comp(), pick_comp(), pick_comp());
    endfunction

    function automatic void add_row(input in_item_t s, input bit typed, input out_item_t want);
        drill_row_t row;
        row.site  = s;
        row.typed = typed;
        row.want  = want;
        drill.push_back(row);
    endfunction

    function automatic string show(input out_item_t r);
        return $sformatf("site %0d up %0d %0d %0d %0d down %0d %0d %0d %0d end %0b",
                         r.site_index, r.new_up1_re, r.new_up1_im, r.new_up2_re,
                         r.new_up2_im, r.new_down1_re, r.new_down1_im, r.new_down2_re,
                         r.new_down2_im, r.sweep_end);
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        bit        bad;
        results_seen++;
        if (awaited_sites.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: %s", show(got));
            return;
        end
        want = awaited_sites.pop_front();
        bad  = (got.site_index !== want.site_index)
            || (got.new_up1_re !== want.new_up1_re) || (got.new_up1_im !== want.new_up1_im)
            || (got.new_up2_re !== want.new_up2_re) || (got.new_up2_im !== want.new_up2_im)
            || (got.new_down1_re !== want.new_down1_re)
            || (got.new_down1_im !== want.new_down1_im)
            || (got.new_down2_re !== want.new_down2_re)
            || (got.new_down2_im !== want.new_down2_im)
            || (got.sweep_end !== want.sweep_end);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
        else if (got.sweep_end)
            sweeps_closed++;
    endtask

    task automatic send_site(input in_item_t s, input bit typed, input out_item_t want);
        if (gap_on && $urandom_range(0, 3) == 0)
        begin
            site_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        site_ch.valid <= 1'b1;
        site_ch.data  <= s;
        do @(posedge clk); while (!site_ch.ready);
        step_out.delete();
        step_lattice(s);
        if (typed)
            awaited_sites.push_back(want);
        else
            foreach (step_out[k])
                awaited_sites.push_back(step_out[k]);
        sites_sent++;
    endtask

    // drop valid, drain, then give the work register time to empty
    task automatic settle();
        site_ch.valid <= 1'b0;
        while (awaited_sites.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_site_count(input logic [APB_DATA_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SITE_COUNT, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_site_count = count_t'(word);
        writes_done++;
    endtask

    task automatic run_phase(input logic [APB_DATA_W-1:0] word, input int items,
                             input bit gaps, input bit stalls, input bit hold);
        settle();
        write_site_count(word);
        gap_on   = gaps;
        stall_on = stalls;
        if (hold)
            hold_request = 1'b1;
        repeat (items) send_site(rand_site(), 1'b0, '0);
    endtask

    // result side: check each beat, then pick ready for the next edge
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left      = 0;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                check_result(result_ch.data);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                stall_left      = $urandom_range(1, 16) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES)
            begin
                $display("timed out after %0d cycles, %0d result beats outstanding",
                         cycle_count, awaited_sites.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        quad_t zq;
        quad_t mx;
        quad_t mn;
        zq = flat_quad(0);
        mx = flat_quad(TOP_Q);
        mn = flat_quad(BOT_Q);

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        site_ch.valid = 1'b0;
        site_ch.data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // hand-worked sites at the reset count; unit a passes u and d straight through
        add_row(make_site(zq, q4(100, -100, 200, -200), UNIT_Q, 0, 0, 0), 1'b0, '0);
        add_row(make_site(mx, mn, UNIT_Q, 0, 0, 0), 1'b0, '0);
        add_row(make_site(mn, q4(1, -1, 2, -2), UNIT_Q, 0, 0, 0), 1'b1,
                make_result(1, zq, q4(1, -1, 2, -2), 1'b0));
        // a = -2 against d at both extremes: clip high, then clip low
        add_row(make_site(zq, mn, BOT_Q, 0, 0, 0), 1'b1, make_result(2, mx, mx, 1'b0));
        add_row(make_site(zq, mx, BOT_Q, 0, 0, 0), 1'b1, make_result(3, mn, mn, 1'b0));
        // one-LSB a: exact halves round up, just below rounds down
        add_row(make_site(q4(8192, -8192, 8191, -8193), zq, 1, 0, 0, 0), 1'b1,
                make_result(4, zq, zq, 1'b0));
        add_row(make_site(q4(300, 400, -500, 600), q4(7, 8, 9, 10), 0, UNIT_Q, 0, 0), 1'b1,
                make_result(5, zq, q4(-8, 7, -10, 9), 1'b0));
        add_row(make_site(q4(11, 12, 13, 14), q4(21, 22, 23, 24), 0, 0, UNIT_Q, 0), 1'b1,
                make_result(6, q4(1, 0, 0, -1), q4(-11, -12, -13, -14), 1'b0));
        add_row(make_site(q4(5, 6, 7, 8), q4(1, 2, 3, 4), 0, 0, 0, UNIT_Q), 1'b1,
                make_result(7, q4(-400, 300, -600, -500), q4(6, -5, 8, -7), 1'b0));
        add_row(make_site(zq, zq, UNIT_Q, 0, 0, 0), 1'b1,
                make_result(8, q4(21, 22, 23, 24), zq, 1'b0));
        add_row(make_site(mn, mn, BOT_Q, BOT_Q, BOT_Q, BOT_Q), 1'b0, '0);
        add_row(make_site(mx, mx, TOP_Q, TOP_Q, TOP_Q, TOP_Q), 1'b0, '0);
        add_row(make_site(flat_quad(21845), flat_quad(21845), 21845, 21845, 21845, 21845),
                1'b0, '0);
        add_row(make_site(flat_quad(-21846), flat_quad(-21846), -21846, -21846, -21846,
                          -21846), 1'b0, '0);
        add_row(make_site(flat_quad(-1), flat_quad(-1), -1, -1, -1, -1), 1'b0, '0);
        add_row(make_site(flat_quad(1), flat_quad(1), 1, 1, 1, 1), 1'b0, '0);
        add_row(make_site(mx, mn, TOP_Q, TOP_Q, BOT_Q, TOP_Q), 1'b0, '0);
        add_row(make_site(mn, mx, BOT_Q, TOP_Q, TOP_Q, BOT_Q), 1'b0, '0);
        add_row(make_site(q4(TOP_Q, BOT_Q, 0, -1), q4(BOT_Q, TOP_Q, 1, 0), UNIT_Q, BOT_Q,
                          TOP_Q, -UNIT_Q), 1'b0, '0);
        add_row(rand_site(), 1'b0, '0);
        add_row(rand_site(), 1'b0, '0);

        gap_on   = 1'b1;
        stall_on = 1'b1;
        foreach (drill[i])
            send_site(drill[i].site, drill[i].typed, drill[i].want);

        // the first shrink lands mid sweep, so the next site closes it
        run_phase(3, 12, 1'b1, 1'b1, 1'b0);
        run_phase(0, 15, 1'b1, 1'b0, 1'b0);
        run_phase(1, 10, 1'b0, 1'b1, 1'b0);
        run_phase(2, 10, 1'b0, 1'b0, 1'b0);
        run_phase(4, 20, 1'b1, 1'b1, 1'b0);
        run_phase(32'hFFFF_F005, 20, 1'b1, 1'b1, 1'b0);
        run_phase(17, 40, 1'b1, 1'b0, 1'b1);
        run_phase(4095, 10, 1'b1, 1'b1, 1'b0);
        run_phase(9, 40, 1'b1, 1'b1, 1'b0);
        run_phase(3, 30, 1'b0, 1'b0, 1'b0);
        run_phase(6, 40, 1'b0, 1'b0, 1'b0);
        settle();

        $display("Streamed %0d site beats, checked %0d result beats over %0d closed sweeps,",
                 sites_sent, results_seen, sweeps_closed);
        $display("%0d site_count writes from below 3 up to 2048; %0d mismatches.",
                 writes_done, mismatches);
        if (mismatches == 0 && awaited_sites.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
